// ===== rtl/rns_crt_modswitch_rescale_top_assert.svh =====
// Assertion macros used by the checker of the rescale block.
// Each macro expects clk and arst_n in scope.
`ifndef RNS_CRT_MODSWITCH_RESCALE_TOP_ASSERT_SVH
`define RNS_CRT_MODSWITCH_RESCALE_TOP_ASSERT_SVH

// same-cycle implication
`define RCMR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RCMR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rcmr_pkg.sv =====
package rcmr_pkg;

	// residue / modulus width
	localparam int MB = 62;
	// quotient width of the modulus-switch division
	localparam int QW = MB + 2;
	// plaintext modulus width
	localparam int TW = 32;
	// width of the per-cell bit stream and quotient
	localparam int BW = (QW > TW) ? QW : TW;
	// configuration port widths
	localparam int CW  = 64;
	localparam int CIW = 3;
	// total pipeline depth, cells plus glue stages
	localparam int NSTG = 4 * MB + QW + TW + 4;

	// configuration register indexes
	typedef enum logic [CIW-1:0] {
		CFG_LIMB_COUNT  = 3'd0,
		CFG_FIRST_MOD   = 3'd1,
		CFG_SECOND_MOD  = 3'd2,
		CFG_FIRST_INV   = 3'd3,
		CFG_PLAIN_MOD   = 3'd4
	} cfg_reg_t;

	// data handed from one cell to the next
	typedef struct packed {
		logic [MB-1:0] acc;   // running remainder, below the modulus
		logic [MB-1:0] a;     // multiplicand, below the modulus
		logic [BW-1:0] quo;   // running quotient
		logic [BW-1:0] bits;  // multiplier bits, MSB consumed first
	} cell_t;

endpackage

// ===== rtl/rns_crt_modswitch_rescale_top.sv =====
// Channel   Handshake               Payload
// in        in_valid / in_stall     phase_first_limb, phase_second_limb
// out       out_valid / out_stall   message_coeff
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data (cfg_ready tied high)
//
// One coefficient per cycle while in_stall is low; the delay from acceptance to
// out_valid is set by the chain of cells, one quotient bit each.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// in_stall rises only when the output register and its skid entry are both full;
// the whole chain then holds until the output drains.
module rns_crt_modswitch_rescale_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [rcmr_pkg::MB-1:0]  phase_first_limb,
	input  logic [rcmr_pkg::MB-1:0]  phase_second_limb,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [rcmr_pkg::TW-1:0]  message_coeff,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [rcmr_pkg::CIW-1:0] cfg_index,
	input  logic [rcmr_pkg::CW-1:0]  cfg_data
);
	import rcmr_pkg::*;

	typedef struct packed {
		logic [MB-1:0] phase0;
		logic [MB-1:0] p1r;
		logic [MB-1:0] invr;
	} g2side_t;

	typedef struct packed {
		logic [QW-1:0] q4;
		logic [MB-1:0] phase0;
	} g5side_t;

	logic [1:0]      limbs_q;
	logic [MB-1:0]   q0_q;
	logic [MB-1:0]   q1_q;
	logic [MB-1:0]   inv_q;
	logic [TW-1:0]   t_q;

	logic            adv;
	logic            tail_full;
	logic [NSTG-1:0] vld_q;

	cell_t   g1a [MB+1];
	cell_t   g1b [MB+1];
	cell_t   g1c [MB+1];
	cell_t   g2  [MB+1];
	g2side_t s2  [MB+1];
	cell_t   g3  [MB+1];
	logic [MB-1:0] s3 [MB+1];
	cell_t   g4  [MB+1];
	logic [MB-1:0] s4 [MB+1];
	cell_t   g5  [QW+1];
	g5side_t s5  [QW+1];
	cell_t   g6  [TW+1];

	logic [MB-1:0] diff_d;
	logic [MB-1:0] diff_q;
	logic [MB-1:0] dph_q;
	logic [MB-1:0] dinv_q;
	logic [QW-1:0] y_q;
	logic [QW-1:0] yq4_q;
	logic [MB-1:0] yph_q;
	logic [QW-1:0] qsum;
	logic [MB-1:0] ph_d;
	logic [MB-1:0] ph_q;
	logic [MB:0]   rsum;
	logic [TW-1:0] qf;
	logic          zero;
	logic [TW-1:0] msg_d;
	logic [TW-1:0] msg_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limbs_q <= 2'd1;
			q0_q    <= MB'(2);
			q1_q    <= MB'(2);
			inv_q   <= MB'(1);
			t_q     <= TW'(2);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LIMB_COUNT: limbs_q <= cfg_data[1:0];
				CFG_FIRST_MOD:  q0_q    <= cfg_data[MB-1:0];
				CFG_SECOND_MOD: q1_q    <= cfg_data[MB-1:0];
				CFG_FIRST_INV:  inv_q   <= cfg_data[MB-1:0];
				CFG_PLAIN_MOD:  t_q     <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// chain advances unless the skid entry is occupied
	assign adv      = !tail_full;
	assign in_stall = tail_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], in_valid};
		end
	end

	// residues: p0 mod q0, p1 mod q1, inverse mod q1
	assign g1a[0] = '{acc: '0, a: MB'(1), quo: '0, bits: BW'(phase_first_limb) << (BW - MB)};
	assign g1b[0] = '{acc: '0, a: MB'(1), quo: '0, bits: BW'(phase_second_limb) << (BW - MB)};
	assign g1c[0] = '{acc: '0, a: MB'(1), quo: '0, bits: BW'(inv_q) << (BW - MB)};

	for (genvar k = 0; k < MB; k++) begin : g_res
		rcmr_cell u_a (.clk(clk), .en(adv), .m(q0_q), .d_i(g1a[k]), .d_q(g1a[k+1]));
		rcmr_cell u_b (.clk(clk), .en(adv), .m(q1_q), .d_i(g1b[k]), .d_q(g1b[k+1]));
		rcmr_cell u_c (.clk(clk), .en(adv), .m(q1_q), .d_i(g1c[k]), .d_q(g1c[k+1]));
	end

	// reduced p0 taken mod q1
	assign g2[0] = '{acc: '0, a: MB'(1), quo: '0, bits: BW'(g1a[MB].acc) << (BW - MB)};
	assign s2[0] = '{phase0: g1a[MB].acc, p1r: g1b[MB].acc, invr: g1c[MB].acc};

	for (genvar k = 0; k < MB; k++) begin : g_p0q1
		rcmr_cell u_c (.clk(clk), .en(adv), .m(q1_q), .d_i(g2[k]), .d_q(g2[k+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				s2[k+1] <= s2[k];
			end
		end
	end

	// (p1 - p0) mod q1
	always_comb begin
		diff_d = s2[MB].p1r - g2[MB].acc;
		if (s2[MB].p1r < g2[MB].acc) begin
			diff_d = diff_d + q1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_q <= diff_d;
			dph_q  <= s2[MB].phase0;
			dinv_q <= s2[MB].invr;
		end
	end

	// s = diff * inverse mod q1
	assign g3[0] = '{acc: '0, a: diff_q, quo: '0, bits: BW'(dinv_q) << (BW - MB)};
	assign s3[0] = dph_q;

	for (genvar k = 0; k < MB; k++) begin : g_crt
		rcmr_cell u_c (.clk(clk), .en(adv), .m(q1_q), .d_i(g3[k]), .d_q(g3[k+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				s3[k+1] <= s3[k];
			end
		end
	end

	// q0 * s divided by q1: quotient and remainder
	assign g4[0] = '{acc: '0, a: g3[MB].acc, quo: '0, bits: BW'(q0_q) << (BW - MB)};
	assign s4[0] = s3[MB];

	for (genvar k = 0; k < MB; k++) begin : g_qs
		rcmr_cell u_c (.clk(clk), .en(adv), .m(q1_q), .d_i(g4[k]), .d_q(g4[k+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				s4[k+1] <= s4[k];
			end
		end
	end

	// leftover numerator: remainder + phase + floor(q1/2)
	always_ff @(posedge clk) begin
		if (adv) begin
			y_q   <= QW'(g4[MB].acc) + QW'(s4[MB]) + QW'(q1_q >> 1);
			yq4_q <= g4[MB].quo[QW-1:0];
			yph_q <= s4[MB];
		end
	end

	// leftover divided by q1
	assign g5[0] = '{acc: '0, a: MB'(1), quo: '0, bits: BW'(y_q) << (BW - QW)};
	assign s5[0] = '{q4: yq4_q, phase0: yph_q};

	for (genvar k = 0; k < QW; k++) begin : g_sw
		rcmr_cell u_c (.clk(clk), .en(adv), .m(q1_q), .d_i(g5[k]), .d_q(g5[k+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				s5[k+1] <= s5[k];
			end
		end
	end

	// switched phase never exceeds q0, so mod q0 is one compare
	always_comb begin
		qsum = s5[QW].q4 + g5[QW].quo[QW-1:0];
		if (limbs_q[1]) begin
			ph_d = (qsum == QW'(q0_q)) ? '0 : qsum[MB-1:0];
		end else begin
			ph_d = s5[QW].phase0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_q <= ph_d;
		end
	end

	// phase * t divided by q0
	assign g6[0] = '{acc: '0, a: ph_q, quo: '0, bits: BW'(t_q) << (BW - TW)};

	for (genvar k = 0; k < TW; k++) begin : g_sc
		rcmr_cell u_c (.clk(clk), .en(adv), .m(q0_q), .d_i(g6[k]), .d_q(g6[k+1]));
	end

	// round half up, reduce mod t, zero moduli give zero
	always_comb begin
		rsum  = {1'b0, g6[TW].acc} + {1'b0, q0_q >> 1};
		qf    = g6[TW].quo[TW-1:0] + TW'(rsum >= {1'b0, q0_q});
		zero  = (q0_q == '0) || (t_q == '0) || (limbs_q[1] && (q1_q == '0));
		msg_d = (zero || (qf == t_q)) ? '0 : qf;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			msg_q <= msg_d;
		end
	end

	rcmr_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.tail_valid (vld_q[NSTG-1]),
		.tail_data  (msg_q),
		.out_stall  (out_stall),
		.full_q     (tail_full),
		.out_valid_q(out_valid),
		.out_data_q (message_coeff)
	);

endmodule

// ===== rtl/rcmr_cell.sv =====
// One step of a shift-add multiply with modular reduction:
// acc = 2*acc + bit*a, reduced by 0, m or 2*m; quo = 2*quo + digit.
module rcmr_cell (
	input  logic                  clk,
	input  logic                  en,
	input  logic [rcmr_pkg::MB-1:0] m,
	input  rcmr_pkg::cell_t       d_i,
	output rcmr_pkg::cell_t       d_q
);
	import rcmr_pkg::*;

	logic [MB+1:0] x;
	logic [MB+1:0] m1;
	logic [MB+1:0] m2;
	logic [MB+1:0] r;
	logic [1:0]    dig;

	// doubled remainder plus conditional multiplicand, then reduce
	always_comb begin
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		x  = {1'b0, d_i.acc, 1'b0} + (d_i.bits[BW-1] ? {2'b00, d_i.a} : '0);
		priority if (x >= m2) begin
			dig = 2'd2;
			r   = x - m2;
		end else if (x >= m1) begin
			dig = 2'd1;
			r   = x - m1;
		end else begin
			dig = 2'd0;
			r   = x;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q.acc  <= r[MB-1:0];
			d_q.a    <= d_i.a;
			d_q.quo  <= {d_i.quo[BW-2:0], 1'b0} + BW'(dig);
			d_q.bits <= {d_i.bits[BW-2:0], 1'b0};
		end
	end

endmodule

// ===== rtl/rcmr_skid.sv =====
// Output register with one skid entry; full stops the pipeline.
module rcmr_skid (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    tail_valid,
	input  logic [rcmr_pkg::TW-1:0] tail_data,
	input  logic                    out_stall,
	output logic                    full_q,
	output logic                    out_valid_q,
	output logic [rcmr_pkg::TW-1:0] out_data_q
);
	import rcmr_pkg::*;

	logic [TW-1:0] skid_q;
	logic          take;

	// output register free or being drained this cycle
	assign take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (full_q) begin
			if (take) begin
				out_valid_q <= 1'b1;
				full_q      <= 1'b0;
			end
		end else if (tail_valid) begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else begin
				full_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (full_q) begin
			if (take) begin
				out_data_q <= skid_q;
			end
		end else if (tail_valid) begin
			if (take) begin
				out_data_q <= tail_data;
			end else begin
				skid_q <= tail_data;
			end
		end
	end

endmodule

// ===== rtl/rcmr_check.sv =====
`include "rns_crt_modswitch_rescale_top_assert.svh"

// Port-level checks on the rescale block.
module rcmr_check (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [rcmr_pkg::MB-1:0]  phase_first_limb,
	input logic [rcmr_pkg::MB-1:0]  phase_second_limb,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [rcmr_pkg::TW-1:0]  message_coeff,
	input logic                     cfg_valid,
	input logic                     cfg_ready,
	input logic [rcmr_pkg::CIW-1:0] cfg_index,
	input logic [rcmr_pkg::CW-1:0]  cfg_data
);
	import rcmr_pkg::*;

	// a stalled result holds
	`RCMR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(message_coeff), "stalled result changed")
	// input back-pressure only when the output side holds a result
	`RCMR_ASSERT_NOW(a_stall_full, in_stall, out_valid, "in_stall without a pending result")
	// back-pressure starts only after a stalled output transaction
	`RCMR_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall), "in_stall rose without output stall")
	// configuration writes are always taken
	`RCMR_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind rns_crt_modswitch_rescale_top rcmr_check u_check (.*);
